// ----- src/tcce_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tcce_pkg;
  localparam int unsigned MaxCols   = 64;
  localparam int unsigned MaxRows   = 32;
  localparam int unsigned Depth     = MaxCols * MaxRows;
  localparam int unsigned AddrW     = $clog2(Depth);
  localparam int unsigned CellW     = 24;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChRight = 8'h91;
  localparam logic [7:0] ChUp    = 8'h90;
  localparam logic [7:0] ChLeft  = 8'h93;
  localparam logic [7:0] ChDown  = 8'h92;
  localparam logic [7:0] ChHome  = 8'h94;
  localparam logic [7:0] ChDel   = 8'h99;
  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChBlank = 8'h20;

  localparam logic [1:0] RegCols = 2'd0;
  localparam logic [1:0] RegRows = 2'd1;
  localparam logic [1:0] RegAttr = 2'd2;
  localparam logic [1:0] RegCore = 2'd3;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OpNone, OpLoad, OpPut, OpRowDown, OpMoveCopy, OpBlank, OpFinish, OpRead, OpCursor
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] src;
    logic [AddrW-1:0] dst;
    logic [7:0]       ch;
  } cmd_t;

  typedef struct packed {
    logic [6:0] cols;
    logic [5:0] rows;
    logic [4:0] row;
    logic [5:0] col;
  } stat_t;
endpackage
`default_nettype wire

// ----- src/tcce_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface tcce_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  char_code;
  logic [10:0] cell_index;
  modport source (output valid, command, char_code, cell_index, input ready);
  modport sink (input valid, command, char_code, cell_index, output ready);
endinterface

interface tcce_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  cursor_row;
  logic [5:0]  cursor_col;
  logic [14:0] cursor_reg;
  logic [15:0] read_attr;
  logic [7:0]  read_char;
  modport source (output valid, cursor_row, cursor_col, cursor_reg, read_attr, read_char,
                  input ready);
  modport sink (input valid, cursor_row, cursor_col, cursor_reg, read_attr, read_char,
                output ready);
endinterface
`default_nettype wire

// ----- src/tcce_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tcce_datapath (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire  [1:0]                    cfg_idx_i,
  input  wire  [31:0]                   cfg_data_i,
  output logic [6:0]                    cfg_cols_o,
  output logic [5:0]                    cfg_rows_o,
  output logic [15:0]                   cfg_attr_o,
  output logic [3:0]                    cfg_core_o,
  input  tcce_pkg::cmd_t                cmd_i,
  output tcce_pkg::stat_t               stat_o,
  output logic [14:0]                   creg_o,
  output logic [15:0]                   rattr_o,
  output logic [7:0]                    rchar_o
);
  logic [tcce_pkg::CellW-1:0] mem_q [tcce_pkg::Depth];
  logic [tcce_pkg::CellW-1:0] rd_q;
  logic [6:0]  cols_q;
  logic [5:0]  rows_q;
  logic [15:0] attr_q;
  logic [3:0]  core_q;
  logic [4:0]  row_q, row_d;
  logic [5:0]  col_q, col_d;
  logic [6:0]  nc;
  logic [5:0]  nr;
  logic [6:0]  ncv;
  logic [5:0]  nrv;
  logic        we;
  logic [tcce_pkg::AddrW-1:0] wa;
  logic [tcce_pkg::CellW-1:0] wd;
  logic [tcce_pkg::AddrW-1:0] curs_addr;
  logic [14:0] prod_q, page_q;
  logic [15:0] rattr_q;
  logic [7:0]  rchar_q;
  logic        rdv;

  function automatic logic [6:0] clc(input logic [6:0] v);
    if (v == 7'd0) return 7'd1;
    if (v > 7'(tcce_pkg::MaxCols)) return 7'(tcce_pkg::MaxCols);
    return v;
  endfunction
  function automatic logic [5:0] clr(input logic [5:0] v);
    if (v == 6'd0) return 6'd1;
    if (v > 6'(tcce_pkg::MaxRows)) return 6'(tcce_pkg::MaxRows);
    return v;
  endfunction

  assign nc = clc(cols_q);
  assign nr = clr(rows_q);
  assign ncv = clc(cfg_data_i[6:0]);
  assign nrv = clr(cfg_data_i[5:0]);
  assign curs_addr = tcce_pkg::AddrW'(row_q * nc + 12'(col_q));

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    we = 1'b0;
    wa = cmd_i.dst;
    wd = {attr_q, tcce_pkg::ChBlank};
    unique case (cmd_i.op)
      tcce_pkg::OpPut: begin
        we = 1'b1;
        wa = curs_addr;
        wd = {attr_q, cmd_i.ch};
        if (7'(col_q) + 7'd1 >= nc) col_d = '0;
        else col_d = col_q + 6'd1;
      end
      tcce_pkg::OpRowDown: begin
        if (6'(row_q) + 6'd1 < nr) row_d = row_q + 5'd1;
        else row_d = 5'(nr - 6'd1);
      end
      tcce_pkg::OpMoveCopy: begin
        we = 1'b1;
        wd = rd_q;
      end
      tcce_pkg::OpBlank: we = 1'b1;
      tcce_pkg::OpCursor: begin
        case (cmd_i.ch)
          tcce_pkg::ChCr: col_d = '0;
          tcce_pkg::ChRight: if (7'(col_q) + 7'd1 < nc) col_d = col_q + 6'd1;
          tcce_pkg::ChUp: if (row_q != 5'd0) row_d = row_q - 5'd1;
          tcce_pkg::ChLeft, tcce_pkg::ChBs: if (col_q != 6'd0) col_d = col_q - 6'd1;
          tcce_pkg::ChDown: if (6'(row_q) + 6'd1 < nr) row_d = row_q + 5'd1;
          tcce_pkg::ChHome: begin
            if (col_q == 6'd0) row_d = '0;
            col_d = '0;
          end
          tcce_pkg::ChFf: begin
            row_d = '0;
            col_d = '0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_q <= mem_q[cmd_i.src];
  end

  assign rdv = (cmd_i.op == tcce_pkg::OpRead);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= 7'd64;
      rows_q <= 6'd32;
      attr_q <= '0;
      core_q <= '0;
      row_q <= '0;
      col_q <= '0;
      rattr_q <= '0;
      rchar_q <= '0;
      prod_q <= '0;
      page_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tcce_pkg::RegCols: begin
            cols_q <= cfg_data_i[6:0];
            if (7'(col_q) >= ncv) col_q <= 6'(ncv - 7'd1);
          end
          tcce_pkg::RegRows: begin
            rows_q <= cfg_data_i[5:0];
            if (6'(row_q) >= nrv) row_q <= 5'(nrv - 6'd1);
          end
          tcce_pkg::RegAttr: attr_q <= cfg_data_i[15:0];
          tcce_pkg::RegCore: core_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end else begin
        row_q <= row_d;
        col_q <= col_d;
      end
      if (cmd_i.op == tcce_pkg::OpLoad) begin
        rattr_q <= '0;
        rchar_q <= '0;
      end
      if (rdv) begin
        rattr_q <= cmd_i.ch[0] ? rd_q[23:8] : 16'd0;
        rchar_q <= cmd_i.ch[0] ? rd_q[7:0] : 8'd0;
      end
      // cursor register in two registered multiplies
      prod_q <= 15'(row_q * nc) + 15'(col_q);
      page_q <= 15'(15'(nc * nr) * core_q);
    end
  end

  assign creg_o = prod_q + page_q;
  assign rattr_o = rattr_q;
  assign rchar_o = rchar_q;
  assign stat_o = '{cols: nc, rows: nr, row: row_q, col: col_q};
  assign cfg_cols_o = cols_q;
  assign cfg_rows_o = rows_q;
  assign cfg_attr_o = attr_q;
  assign cfg_core_o = core_q;

  ap_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == tcce_pkg::OpPut |-> 7'(col_q) < nc) else $error("col out of range");
  ap_rowr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == tcce_pkg::OpRowDown |=> 6'(row_q) < nr) else $error("row out of range");
  ap_rd0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == tcce_pkg::OpLoad |=> rattr_q == 16'd0 && rchar_q == 8'd0)
    else $error("read fields not cleared");
endmodule
`default_nettype wire

// ----- src/tcce_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tcce_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  tcce_in_if.sink          in_if,
  input  wire              out_busy_i,
  output logic             out_load_o,
  input  tcce_pkg::stat_t  stat_i,
  output tcce_pkg::cmd_t   cmd_o
);
  typedef enum logic [3:0] {
    StIdle, StDecode, StPut, StRowDown, StScroll, StScrollW, StFill, StDel, StDelW,
    StRead, StRead2, StCalc, StCalc2, StDone
  } state_e;

  localparam int unsigned AW = tcce_pkg::AddrW;

  state_e       state_q;
  logic         cmd_q;
  logic [7:0]   ch_q;
  logic [10:0]  idx_q;
  logic [2:0]   tabs_q;
  logic [AW:0]  k_q;
  logic [AW:0]  end_q;
  logic [AW:0]  base_q;
  logic [AW:0]  c1, ce;

  assign c1 = (AW+1)'(stat_i.cols);
  assign ce = (AW+1)'(stat_i.row * stat_i.cols);
  assign in_if.ready = (state_q == StIdle);

  always_comb begin
    cmd_o = '{op: tcce_pkg::OpNone, src: '0, dst: '0, ch: ch_q};
    unique case (state_q)
      StIdle: if (in_if.valid) cmd_o.op = tcce_pkg::OpLoad;
      StPut: cmd_o.op = tcce_pkg::OpPut;
      StRowDown: cmd_o.op = tcce_pkg::OpRowDown;
      StScroll, StDel: cmd_o.src = AW'(k_q + ((state_q == StScroll) ? c1 : (AW+1)'(1)));
      StScrollW, StDelW: begin
        cmd_o.op = (k_q < end_q) ? tcce_pkg::OpMoveCopy : tcce_pkg::OpBlank;
        cmd_o.dst = AW'(k_q);
        cmd_o.src = AW'(k_q + ((state_q == StScrollW) ? c1 : (AW+1)'(1)));
      end
      StFill: begin
        cmd_o.op = tcce_pkg::OpBlank;
        cmd_o.dst = AW'(k_q);
      end
      StRead: cmd_o.src = AW'(idx_q);
      StRead2: begin
        cmd_o.op = tcce_pkg::OpRead;
        cmd_o.ch = {7'd0, 12'(idx_q) < 12'(tcce_pkg::Depth)};
      end
      StDecode: begin
        if (!cmd_q && (ch_q == tcce_pkg::ChCr || ch_q == tcce_pkg::ChRight ||
            ch_q == tcce_pkg::ChUp || ch_q == tcce_pkg::ChLeft ||
            ch_q == tcce_pkg::ChDown || ch_q == tcce_pkg::ChHome ||
            ch_q == tcce_pkg::ChFf || (ch_q == tcce_pkg::ChBs && stat_i.col != 6'd0)))
          cmd_o.op = tcce_pkg::OpCursor;
      end
      default: ;
    endcase
    if (state_q == StPut && ch_q == tcce_pkg::ChTab) cmd_o.ch = tcce_pkg::ChBlank;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cmd_q <= 1'b0;
      ch_q <= '0;
      idx_q <= '0;
      tabs_q <= '0;
      k_q <= '0;
      end_q <= '0;
      base_q <= '0;
      out_load_o <= 1'b0;
    end else begin
      out_load_o <= 1'b0;
      unique case (state_q)
        StIdle: if (in_if.valid) begin
          cmd_q <= in_if.command;
          ch_q <= in_if.char_code;
          idx_q <= in_if.cell_index;
          tabs_q <= 3'd4;
          state_q <= StDecode;
        end
        StDecode: begin
          if (cmd_q) state_q <= StRead;
          else begin
            unique case (ch_q)
              tcce_pkg::ChLf: state_q <= StRowDown;
              tcce_pkg::ChCr, tcce_pkg::ChRight, tcce_pkg::ChUp, tcce_pkg::ChLeft,
              tcce_pkg::ChDown, tcce_pkg::ChHome: state_q <= StCalc;
              tcce_pkg::ChFf: begin
                k_q <= '0;
                end_q <= (AW+1)'(stat_i.cols * stat_i.rows);
                state_q <= StFill;
              end
              tcce_pkg::ChDel, tcce_pkg::ChBs: begin
                if (ch_q == tcce_pkg::ChBs && stat_i.col == 6'd0) state_q <= StCalc;
                else begin
                  // backspace cursor step lands this cycle, so col-1
                  k_q <= ce + (AW+1)'(stat_i.col) -
                         ((ch_q == tcce_pkg::ChBs) ? (AW+1)'(1) : '0);
                  end_q <= ce + c1 - (AW+1)'(1);
                  state_q <= StDel;
                end
              end
              default: state_q <= StPut;
            endcase
          end
        end
        StPut: begin
          tabs_q <= tabs_q - 3'd1;
          if (7'(stat_i.col) + 7'd1 >= stat_i.cols) state_q <= StRowDown;
          else if (ch_q == tcce_pkg::ChTab && tabs_q != 3'd1) state_q <= StPut;
          else state_q <= StCalc;
        end
        StRowDown: begin
          if (6'(stat_i.row) + 6'd1 >= stat_i.rows) begin
            k_q <= '0;
            end_q <= (AW+1)'(stat_i.cols * (stat_i.rows - 6'd1));
            base_q <= (AW+1)'(stat_i.cols * stat_i.rows);
            state_q <= StScroll;
          end else if (ch_q == tcce_pkg::ChTab && tabs_q != 3'd0) state_q <= StPut;
          else state_q <= StCalc;
        end
        StScroll: state_q <= StScrollW;
        StScrollW: begin
          k_q <= k_q + (AW+1)'(1);
          if (k_q + (AW+1)'(1) >= base_q) begin
            if (ch_q == tcce_pkg::ChTab && tabs_q != 3'd0) state_q <= StPut;
            else state_q <= StCalc;
          end else state_q <= StScroll;
        end
        StFill: begin
          k_q <= k_q + (AW+1)'(1);
          if (k_q + (AW+1)'(1) >= end_q) state_q <= StCalc;
        end
        StDel: state_q <= StDelW;
        StDelW: begin
          k_q <= k_q + (AW+1)'(1);
          if (k_q >= end_q) state_q <= StCalc;
          else state_q <= StDel;
        end
        StRead: state_q <= StRead2;
        StRead2: state_q <= StCalc;
        StCalc: state_q <= StCalc2;
        StCalc2: state_q <= StDone;
        StDone: if (!out_busy_i) begin
          out_load_o <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  ap_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> state_q == StDecode) else $error("item not taken");
  ap_ld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_o |-> $past(state_q) == StDone) else $error("stray result");
  ap_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFill |-> k_q < end_q) else $error("fill overrun");
endmodule
`default_nettype wire

// ----- src/text_console_char_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// text console character engine
// in_if carries one request: command 0 shows char_code, command 1 reads the
// cell at cell_index. out_if returns one result per request: cursor row and
// column, the cursor register (row*cols+col plus core page) and the read cell.
// the controller takes one request at a time, and the next request is taken
// at the edge the result is loaded. scroll walks the store through its single
// write port, reading and then writing each cell (cols*rows cells);
// delete walks the rest of the row the same way, form feed blanks one cell a
// cycle. the result waits in an output register; while the receiver stalls,
// the next request is taken and worked on, and holds in its last state.
// reset homes the cursor and sets 64 columns, 32 rows; the screen store is
// left as it is until written. apb writes at byte address 4*i; the user must
// write only while idle, the block itself does not enforce it.
module text_console_char_engine (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  tcce_in_if.sink     in_if,
  tcce_out_if.source  out_if
);
  tcce_pkg::cmd_t  cmd;
  tcce_pkg::stat_t stat;
  logic        load;
  logic        cfg_we;
  logic [6:0]  cols;
  logic [5:0]  rows;
  logic [15:0] attr;
  logic [3:0]  core;
  logic [14:0] creg;
  logic [15:0] rattr;
  logic [7:0]  rchar;
  logic        ov_q;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[1:0] == 2'd0);

  always_comb begin
    case (paddr[3:2])
      tcce_pkg::RegCols: prdata = {25'd0, cols};
      tcce_pkg::RegRows: prdata = {26'd0, rows};
      tcce_pkg::RegAttr: prdata = {16'd0, attr};
      default:           prdata = {28'd0, core};
    endcase
  end

  tcce_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_if, .out_busy_i(ov_q && !out_if.ready),
    .out_load_o(load), .stat_i(stat), .cmd_o(cmd)
  );

  tcce_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_idx_i(paddr[3:2]), .cfg_data_i(pwdata),
    .cfg_cols_o(cols), .cfg_rows_o(rows), .cfg_attr_o(attr), .cfg_core_o(core),
    .cmd_i(cmd), .stat_o(stat), .creg_o(creg), .rattr_o(rattr), .rchar_o(rchar)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      out_if.cursor_row <= '0;
      out_if.cursor_col <= '0;
      out_if.cursor_reg <= '0;
      out_if.read_attr <= '0;
      out_if.read_char <= '0;
    end else begin
      if (out_if.ready) ov_q <= 1'b0;
      if (load) begin
        ov_q <= 1'b1;
        out_if.cursor_row <= stat.row;
        out_if.cursor_col <= stat.col;
        out_if.cursor_reg <= creg;
        out_if.read_attr <= rattr;
        out_if.read_char <= rchar;
      end
    end
  end
  assign out_if.valid = ov_q;
endmodule
`default_nettype wire
